[src/bpfa_pkg.sv]
// Shared types and constants of the bitmap page frame allocator.
package bpfa_pkg;

   localparam int NUM_FRAMES_DEFAULT = 4096;
   localparam int PAGE_SHIFT_DEFAULT = 12;
   localparam int WORD_BITS = 64;
   localparam int COUNT_W = 13;
   localparam logic [COUNT_W-1:0] COUNT_SAT = 13'h1FFF;

   typedef enum logic [2:0] {
      FUNC_ALLOC_ONE = 3'd0,
      FUNC_ALLOC_RUN = 3'd1,
      FUNC_FREE_ONE  = 3'd2,
      FUNC_MARK_USED = 3'd3,
      FUNC_MARK_FREE = 3'd4
   } func_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_SCAN,
      ST_FILL,
      ST_RESP
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic init_step;
      logic scan_step;
      logic fill_step;
      logic finish;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic init_done;
      logic scan_done;
      logic scan_hit;
      logic fill_done;
      logic fill_needed;
      logic is_scan;
   } sts_type;

endpackage

[src/bitmap_page_frame_allocator.sv]
// Top level of the bitmap page frame allocator.
// The block keeps one used/free bit per page frame and answers one beat on the
// rsp_ channel for every beat taken on the req_ channel. req_func selects
// allocate-one, allocate-run, free-one, mark-range-used or mark-range-free.
// Allocations search first fit, one 64-bit bitmap word per cycle; a hit is then
// written back by a fill pass that steps through every word from word zero up to
// the last word of the run, one word per cycle.
// The answer beat follows the request beat through the scan pass, if any, and
// then the fill pass, if any.
// Only one request is in flight: req_stall stays high until the answer beat has
// been taken, and the next request beat can be taken in the cycle after.
// While rsp_stall is high the answer holds steady.
// After reset the block sets every word to used, with req_stall high;
// the page counter starts at zero.
// A request is taken when req_valid is high and req_stall low; an answer
// when rsp_valid is high and rsp_stall low.
module bitmap_page_frame_allocator
   import bpfa_pkg::*;
#(
   parameter int NUM_FRAMES = NUM_FRAMES_DEFAULT,
   parameter int PAGE_SHIFT = PAGE_SHIFT_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_func,
   input  logic [31:0]        req_addr,
   input  logic [31:0]        req_length,
   input  logic [12:0]        req_count,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [31:0]        rsp_page_addr,
   output logic               rsp_ok,
   output logic [COUNT_W-1:0] rsp_allocated_pages
);

   cmd_type cmd;
   sts_type sts;

   // The controller sequences clear, scan, fill and answer phases.
   bpfa_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .sts(sts), .cmd(cmd)
   );

   // The datapath holds the bitmap memory and the page counter.
   bpfa_dp #(.NUM_FRAMES(NUM_FRAMES), .PAGE_SHIFT(PAGE_SHIFT)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .req_func(req_func), .req_addr(req_addr),
      .req_length(req_length), .req_count(req_count),
      .rsp_page_addr(rsp_page_addr), .rsp_ok(rsp_ok),
      .rsp_allocated_pages(rsp_allocated_pages)
   );

endmodule

[src/bpfa_ctrl.sv]
// Controller state machine of the bitmap page frame allocator.
module bpfa_ctrl
   import bpfa_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_INIT: begin
            cmd.init_step = 1'b1;
            if (sts.init_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // Non-scan requests pass straight through to the fill state.
            cmd.scan_step = sts.is_scan;
            if (!sts.is_scan || sts.scan_done) begin
               state_in = ST_FILL;
            end
         end
         ST_FILL: begin
            cmd.fill_step = sts.fill_needed;
            if (!sts.fill_needed || sts.fill_done) begin
               cmd.finish = 1'b1;
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_INIT;
      endcase
   end

   a_resp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid) else $error("response dropped");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("accept while answering");
   a_init_no_accept: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_INIT |-> req_stall) else $error("accept during clear");

endmodule

[src/bpfa_dp.sv]
// Datapath of the bitmap page frame allocator: bitmap memory, scan and fill.
module bpfa_dp
   import bpfa_pkg::*;
#(
   parameter int NUM_FRAMES = NUM_FRAMES_DEFAULT,
   parameter int PAGE_SHIFT = PAGE_SHIFT_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output sts_type             sts,
   input  logic [2:0]          req_func,
   input  logic [31:0]         req_addr,
   input  logic [31:0]         req_length,
   input  logic [12:0]         req_count,
   output logic [31:0]         rsp_page_addr,
   output logic                rsp_ok,
   output logic [COUNT_W-1:0]  rsp_allocated_pages
);

   localparam int WORDS = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
   localparam int WA_W = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int FR_W = $clog2(NUM_FRAMES) + 1;
   localparam int LAST_BITS = NUM_FRAMES - (WORDS - 1) * WORD_BITS;
   localparam logic [FR_W-1:0] NF = FR_W'(NUM_FRAMES);

   // Bitmap memory: one registered read and at most one write per cycle.
   logic [WORD_BITS-1:0] mem [WORDS];

   logic [2:0]         func_ff;
   logic [FR_W-1:0]    need_ff;
   logic [FR_W-1:0]    first_ff, last_ff;
   logic               fail_ff, mark_ff;
   logic [WA_W:0]      wa_ff, wa_in;
   logic [FR_W-1:0]    run_ff, run_in;
   logic [FR_W-1:0]    start_in;
   logic               hit_ff, hit_in;
   logic [31:0]        page_ff;
   logic               ok_ff;
   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   logic [WORD_BITS-1:0] rd_word_ff;

   logic is_alloc, is_scan_sig;
   assign is_alloc = (func_ff == FUNC_ALLOC_ONE) || (func_ff == FUNC_ALLOC_RUN);
   assign is_scan_sig = is_alloc && !fail_ff;

   // Frame range of the request, worked out in 33 bits so a nonzero length does not wrap.
   logic [32:0] end_addr;
   logic [32:0] first_fr, last_fr;
   assign end_addr = {1'b0, req_addr} + {1'b0, req_length} - 33'd1;
   assign first_fr = {1'b0, req_addr} >> PAGE_SHIFT;
   assign last_fr  = end_addr >> PAGE_SHIFT;

   // Valid bits of the current word (tail word may be partial).
   logic [WORD_BITS-1:0] in_map;
   always_comb begin
      in_map = '1;
      if (wa_ff[WA_W-1:0] == WA_W'(WORDS - 1)) begin
         in_map = (LAST_BITS == WORD_BITS) ? '1 : ((64'd1 << LAST_BITS) - 64'd1);
      end
   end

   logic [WORD_BITS-1:0] freebits;
   assign freebits = ~rd_word_ff & in_map;

   // A run can end at bit b in two ways: every bit from 0 to b is free and the
   // run carried in from earlier words makes up the rest, or the whole run lies
   // inside this word. The lowest such bit is the hit. All bits are judged in
   // parallel, so no counter ripples across the word.
   logic [WORD_BITS-1:0] low_free, inner_run, hit_bits;
   logic [FR_W-1:0]      rem_m1;
   logic [5:0]           hit_pos;
   logic [6:0]           top_free;
   assign rem_m1 = need_ff - run_ff - 1'b1;

   always_comb begin
      for (int b = 0; b < WORD_BITS; b++) begin
         low_free[b] = &(freebits | (({WORD_BITS{1'b1}} << b) << 1));
      end
      inner_run = freebits;
      for (int k = 1; k < WORD_BITS; k++) begin
         inner_run = inner_run & ((freebits << k) | {WORD_BITS{FR_W'(k) >= need_ff}});
      end
      for (int b = 0; b < WORD_BITS; b++) begin
         hit_bits[b] = (low_free[b] && (FR_W'(b) >= rem_m1)) ||
                       (inner_run[b] && (need_ff <= FR_W'(WORD_BITS)));
      end
      hit_pos = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (hit_bits[b]) begin
            hit_pos = 6'(b);
         end
      end
      top_free = '0;
      for (int b = 0; b < WORD_BITS; b++) begin
         if (!freebits[b]) begin
            top_free = 7'(WORD_BITS - 1 - b);
         end
      end
   end

   assign hit_in = |hit_bits;
   assign start_in = FR_W'({wa_ff[WA_W-1:0], hit_pos}) + FR_W'(1) - need_ff;
   assign run_in = low_free[WORD_BITS-1] ? run_ff + FR_W'(WORD_BITS) : FR_W'(top_free);

   // Fill mask for word wa_ff over [first_ff, last_ff].
   logic [WORD_BITS-1:0] fmask;
   always_comb begin
      logic [FR_W-1:0] fb;
      fmask = '0;
      for (int b = 0; b < WORD_BITS; b++) begin
         fb = FR_W'({wa_ff[WA_W-1:0], 6'(b)});
         fmask[b] = (fb >= first_ff) && (fb <= last_ff) && (fb < NF);
      end
   end

   logic fill_range_ok;
   assign fill_range_ok = (first_ff <= last_ff) && (first_ff < NF);

   // The read address runs one step ahead, so rd_word_ff always holds word wa_ff.
   always_ff @(posedge clock) begin
      rd_word_ff <= mem[wa_in[WA_W-1:0]];
      if (cmd.init_step) begin
         mem[wa_ff[WA_W-1:0]] <= '1;
      end else if (cmd.fill_step) begin
         if (mark_ff) begin
            mem[wa_ff[WA_W-1:0]] <= rd_word_ff | fmask;
         end else begin
            mem[wa_ff[WA_W-1:0]] <= rd_word_ff & ~fmask;
         end
      end
   end

   always_comb begin
      wa_in = wa_ff;
      if (cmd.load) begin
         wa_in = '0;
      end else if (cmd.init_step || cmd.scan_step) begin
         wa_in = wa_ff + 1'b1;
      end else if (cmd.fill_step) begin
         wa_in = wa_ff + 1'b1;
      end
      if (cmd.scan_step && (hit_in || wa_ff == (WA_W + 1)'(WORDS - 1))) begin
         wa_in = '0;
      end
      if (cmd.init_step && wa_ff == (WA_W + 1)'(WORDS - 1)) begin
         wa_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wa_ff <= '0;
         cnt_ff <= '0;
         hit_ff <= 1'b0;
      end else begin
         wa_ff <= wa_in;
         if (cmd.load) begin
            hit_ff <= 1'b0;
         end else if (cmd.scan_step) begin
            hit_ff <= hit_in;
         end
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= req_func;
         run_ff <= '0;
         if (req_func == FUNC_ALLOC_ONE) begin
            need_ff <= FR_W'(1);
            fail_ff <= 1'b0;
         end else begin
            need_ff <= FR_W'(req_count);
            fail_ff <= (req_count == '0) || ({19'd0, req_count} > 32'(NUM_FRAMES));
         end
         mark_ff <= (req_func == FUNC_MARK_USED);
         if (req_func == FUNC_FREE_ONE) begin
            first_ff <= (first_fr >= 33'(NUM_FRAMES)) ? NF : FR_W'(first_fr);
            last_ff <= (first_fr >= 33'(NUM_FRAMES)) ? NF : FR_W'(first_fr);
         end else if (req_length == '0 || first_fr >= 33'(NUM_FRAMES)) begin
            first_ff <= NF;
            last_ff <= '0;
         end else begin
            first_ff <= FR_W'(first_fr);
            last_ff <= (last_fr >= 33'(NUM_FRAMES)) ? NF - 1'b1 : FR_W'(last_fr);
         end
      end else if (cmd.scan_step) begin
         run_ff <= run_in;
         if (hit_in) begin
            // Convert the found run into a fill range.
            first_ff <= start_in;
            last_ff <= start_in + need_ff - 1'b1;
            mark_ff <= 1'b1;
         end
      end
   end

   // Fill words from word zero up to the last touched word.
   logic [WA_W:0] last_wa;
   assign last_wa = (WA_W + 1)'(last_ff >> 6);

   logic filling;
   always_comb begin
      sts.init_done = (wa_ff == (WA_W + 1)'(WORDS - 1));
      sts.is_scan = is_scan_sig;
      sts.scan_done = hit_in || (wa_ff == (WA_W + 1)'(WORDS - 1));
      sts.scan_hit = hit_ff;
      filling = ((func_ff == FUNC_FREE_ONE) || (func_ff == FUNC_MARK_USED) ||
                 (func_ff == FUNC_MARK_FREE) || (is_scan_sig && hit_ff)) && fill_range_ok;
      sts.fill_needed = filling;
      sts.fill_done = (wa_ff >= last_wa);
   end

   // Counter update and result word.
   logic [COUNT_W:0] sum;
   assign sum = {1'b0, cnt_ff} + (COUNT_W + 1)'(need_ff);
   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.finish) begin
         if (is_scan_sig && hit_ff) begin
            cnt_in = (sum > {1'b0, COUNT_SAT}) ? COUNT_SAT : sum[COUNT_W-1:0];
         end else if (func_ff == FUNC_FREE_ONE && first_ff < NF && cnt_ff != '0) begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         page_ff <= (is_scan_sig && hit_ff) ? 32'(64'(first_ff) << PAGE_SHIFT) : '0;
         ok_ff <= is_alloc ? (is_scan_sig && hit_ff) :
                  ((func_ff == FUNC_FREE_ONE) || (func_ff == FUNC_MARK_USED) ||
                   (func_ff == FUNC_MARK_FREE));
      end
   end

   assign rsp_page_addr = page_ff;
   assign rsp_ok = ok_ff;
   assign rsp_allocated_pages = cnt_ff;

   a_fill_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.fill_step |-> wa_ff <= last_wa) else $error("fill past last word");
   a_scan_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.scan_step && cmd.fill_step)) else $error("scan and fill overlap");
   a_cnt_step: assert property (@(posedge clock) disable iff (reset)
      !$past(cmd.finish) && !$past(reset) |-> $stable(cnt_ff)) else $error("count moved");

endmodule

[verif/allocator_checker.sv]
// Checker that predicts and compares every answer beat of the page frame allocator.
module allocator_checker
   import bpfa_pkg::*;
#(
   parameter int NUM_FRAMES = NUM_FRAMES_DEFAULT,
   parameter int PAGE_SHIFT = PAGE_SHIFT_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [2:0]         req_func,
   input  logic [31:0]        req_addr,
   input  logic [31:0]        req_length,
   input  logic [12:0]        req_count,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [31:0]        rsp_page_addr,
   input  logic               rsp_ok,
   input  logic [COUNT_W-1:0] rsp_allocated_pages,
   output int                 fail_count,
   output int                 answers_pending
);

   typedef struct {
      logic [31:0]        page_addr;
      logic               ok;
      logic [COUNT_W-1:0] pages;
   } answer_type;

   bit [NUM_FRAMES-1:0] frame_used;
   logic [COUNT_W-1:0]  pages_out;
   answer_type          answers_due[$];

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
      fail_count++;
   endtask

   function automatic void add_pages(input longint unsigned n);
      longint unsigned sum;
      sum = longint'(pages_out) + n;
      pages_out = (sum > longint'(COUNT_SAT)) ? COUNT_SAT : sum[COUNT_W-1:0];
   endfunction

   function automatic answer_type serve_request(input logic [2:0] fn, input logic [31:0] addr,
                                                input logic [31:0] len, input logic [12:0] cnt);
      answer_type      ans;
      longint unsigned first, last, run;
      ans = '{32'd0, 1'b0, '0};
      case (fn)
         FUNC_ALLOC_ONE: begin
            for (int f = 0; f < NUM_FRAMES; f++) begin
               if (!frame_used[f]) begin
                  frame_used[f] = 1'b1;
                  add_pages(1);
                  ans.page_addr = 32'(longint'(f) << PAGE_SHIFT);
                  ans.ok = 1'b1;
                  break;
               end
            end
         end
         FUNC_ALLOC_RUN: begin
            run = 0;
            if (cnt != 0 && cnt <= NUM_FRAMES) begin
               for (int f = 0; f < NUM_FRAMES; f++) begin
                  run = frame_used[f] ? 0 : run + 1;
                  if (run == cnt) begin
                     for (int g = f + 1 - cnt; g <= f; g++) frame_used[g] = 1'b1;
                     add_pages(cnt);
                     ans.page_addr = 32'(longint'(f + 1 - cnt) << PAGE_SHIFT);
                     ans.ok = 1'b1;
                     break;
                  end
               end
            end
         end
         FUNC_FREE_ONE: begin
            first = longint'(addr) >> PAGE_SHIFT;
            if (first < NUM_FRAMES) begin
               frame_used[first] = 1'b0;
               if (pages_out != 0) pages_out--;
            end
            ans.ok = 1'b1;
         end
         FUNC_MARK_USED, FUNC_MARK_FREE: begin
            if (len != 0) begin
               // The end of the range is worked out in 64 bits, so it never wraps.
               first = longint'(addr) >> PAGE_SHIFT;
               last = (longint'(addr) + longint'(len) - 1) >> PAGE_SHIFT;
               if (last >= NUM_FRAMES) last = NUM_FRAMES - 1;
               for (longint unsigned f = first; f <= last; f++)
                  frame_used[f] = (fn == FUNC_MARK_USED);
            end
            ans.ok = 1'b1;
         end
         default: ;
      endcase
      ans.pages = pages_out;
      return ans;
   endfunction

   always @(posedge clock) begin
      answer_type want;
      if (reset) begin
         frame_used <= '1;
         pages_out <= '0;
         answers_due.delete();
         fail_count <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (answers_due.size() == 0) begin
               report("unexpected answer beat", rsp_page_addr, 32'd0);
            end else begin
               want = answers_due.pop_front();
               if (rsp_page_addr !== want.page_addr)
                  report("page_addr", rsp_page_addr, want.page_addr);
               if (rsp_ok !== want.ok)
                  report("ok", 32'(rsp_ok), 32'(want.ok));
               if (rsp_allocated_pages !== want.pages)
                  report("allocated_pages", 32'(rsp_allocated_pages), 32'(want.pages));
            end
         end
         if (req_valid && !req_stall)
            answers_due.push_back(serve_request(req_func, req_addr, req_length, req_count));
      end
      answers_pending = answers_due.size();
   end

endmodule

[verif/testbench.sv]
// Top of the page frame allocator testbench: stimulus, answer stalls and the verdict.
module testbench
   import bpfa_pkg::*;
();

   localparam int FRAMES = NUM_FRAMES_DEFAULT;
   localparam int SHIFT = PAGE_SHIFT_DEFAULT;
   // Longest quiet stretch allowed: the long hold-off plus full scans, several times over.
   localparam int QUIET_LIMIT = 4000;
   localparam int RANDOM_ITEMS = 600;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [2:0]         req_func;
   logic [31:0]        req_addr;
   logic [31:0]        req_length;
   logic [12:0]        req_count;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [31:0]        rsp_page_addr;
   logic               rsp_ok;
   logic [COUNT_W-1:0] rsp_allocated_pages;
   int                 fail_count;
   int                 answers_pending;
   bit                 hold_off_request;
   bit                 quiet_answers;

   bitmap_page_frame_allocator dut (.*);

   allocator_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Synchronous reset at the start; every input is known from time zero.
   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_func = FUNC_ALLOC_ONE;
      req_addr = '0;
      req_length = '0;
      req_count = '0;
      rsp_stall = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
   end

   // The answer side stalls at random. Once, on request, it holds off for a long stretch
   // while the sender keeps offering, so the block has to stall its request channel.
   initial begin
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            rsp_stall <= 1'b1;
            repeat (300) @(posedge clock);
            hold_off_request = 1'b0;
            rsp_stall <= 1'b0;
         end else if (quiet_answers) begin
            rsp_stall <= 1'b0;
         end else if ($urandom_range(0, 99) < 3) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(10, 60)) @(posedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < 30);
         end
      end
   end

   // Watchdog: ends the run when no beat moves on either channel for too long.
   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
         if (quiet >= QUIET_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // Offers one request beat and returns once it has been taken. Valid stays high
   // afterwards, so back-to-back beats need no extra edge.
   task automatic send_request(input logic [2:0] fn, input logic [31:0] addr,
                               input logic [31:0] len, input logic [12:0] cnt);
      req_valid <= 1'b1;
      req_func <= fn;
      req_addr <= addr;
      req_length <= len;
      req_count <= cnt;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic sender_gap();
      int cycles;
      if ($urandom_range(0, 99) < 50) return;
      cycles = ($urandom_range(0, 99) < 8) ? $urandom_range(20, 80) : $urandom_range(1, 3);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   function automatic logic [31:0] frame_address(input bit low_end);
      logic [31:0] frame;
      frame = low_end ? $urandom_range(0, 255) : $urandom_range(0, FRAMES - 1);
      return (frame << SHIFT) | ($urandom_range(0, 99) < 50 ? $urandom_range(0, 4095) : 0);
   endfunction

   task automatic random_request();
      int          pick;
      logic [2:0]  fn;
      logic [31:0] addr;
      logic [31:0] len;
      logic [12:0] cnt;
      pick = $urandom_range(0, 99);
      fn = (pick < 25) ? FUNC_ALLOC_ONE : (pick < 45) ? FUNC_ALLOC_RUN :
           (pick < 70) ? FUNC_FREE_ONE : (pick < 80) ? FUNC_MARK_USED : FUNC_MARK_FREE;
      // Most addresses land inside the bitmap, mainly where first fit allocates.
      pick = $urandom_range(0, 99);
      addr = (pick < 12) ? $urandom() : frame_address(pick < 60);
      pick = $urandom_range(0, 99);
      len = (pick < 5) ? 32'd0 : (pick < 12) ? $urandom() :
            (pick < 15) ? 32'hFFFF_FFFF : $urandom_range(1, 96 << SHIFT);
      pick = $urandom_range(0, 99);
      cnt = 13'((pick < 4) ? 0 : (pick < 7) ? FRAMES :
                (pick < 10) ? $urandom_range(0, FRAMES) : $urandom_range(1, 16));
      send_request(fn, addr, len, cnt);
   endtask

   initial begin
      hold_off_request = 1'b0;
      quiet_answers = 1'b0;
      @(negedge reset);
      @(posedge clock);

      // Directed part. Every frame starts used, so the first allocations must fail.
      send_request(FUNC_ALLOC_ONE, 32'd0, 32'd0, 13'd0);
      send_request(FUNC_ALLOC_RUN, 32'd0, 32'd0, 13'd1);
      // Free of frame zero answers ok and leaves the counter at zero.
      send_request(FUNC_FREE_ONE, 32'd0, 32'd0, 13'd0);
      // Allocating frame zero succeeds with address zero.
      send_request(FUNC_ALLOC_ONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 13'h1FFF & 13'(FRAMES));
      // Empty range and a range starting above the bitmap change nothing.
      send_request(FUNC_MARK_FREE, 32'h0000_3000, 32'd0, 13'd0);
      send_request(FUNC_MARK_FREE, 32'hFFFF_F000, 32'hFFFF_FFFF, 13'd0);
      send_request(FUNC_ALLOC_ONE, 32'd0, 32'd0, 13'd0);
      // Free every frame, take the whole map twice over to saturate the counter.
      send_request(FUNC_MARK_FREE, 32'd0, 32'hFFFF_FFFF, 13'd0);
      send_request(FUNC_ALLOC_RUN, 32'd0, 32'd0, 13'(FRAMES));
      send_request(FUNC_MARK_FREE, 32'd0, 32'hFFFF_FFFF, 13'd0);
      send_request(FUNC_ALLOC_RUN, 32'd0, 32'd0, 13'(FRAMES));
      send_request(FUNC_ALLOC_RUN, 32'd0, 32'd0, 13'd0);
      // A free of a frame beyond the bitmap answers ok and keeps the counter.
      send_request(FUNC_FREE_ONE, 32'hFFFF_FFFF, 32'd0, 13'd0);
      send_request(FUNC_FREE_ONE, 32'h0000_5123, 32'd0, 13'd0);
      // Freeing the same frame again still drops the counter.
      send_request(FUNC_FREE_ONE, 32'h0000_5000, 32'd0, 13'd0);
      send_request(FUNC_MARK_FREE, 32'h0001_0FFF, 32'h0000_2002, 13'd0);
      send_request(FUNC_ALLOC_RUN, 32'd0, 32'd0, 13'd4);
      send_request(FUNC_ALLOC_RUN, 32'd0, 32'd0, 13'd3);
      send_request(FUNC_ALLOC_ONE, 32'd0, 32'd0, 13'd0);
      send_request(FUNC_MARK_USED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 13'd0);
      send_request(FUNC_MARK_USED, 32'h0000_0000, 32'h0000_0001, 13'd0);
      // Run too long for what is free.
      send_request(FUNC_ALLOC_RUN, 32'd0, 32'd0, 13'd2);
      // Reopen the whole map before the random part.
      send_request(FUNC_MARK_FREE, 32'd0, 32'hFFFF_FFFF, 13'd0);

      // Random part, with one long answer hold-off and one full drain along the way.
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS / 3) hold_off_request = 1'b1;
         if (i == RANDOM_ITEMS / 2) begin
            req_valid <= 1'b0;
            @(posedge clock);
            while (answers_pending != 0) @(posedge clock);
         end
         quiet_answers = (i >= 400 && i < 450);
         random_request();
         sender_gap();
      end
      req_valid <= 1'b0;
      quiet_answers = 1'b0;

      // One edge first, so the checker has logged the last request beat.
      @(posedge clock);
      while (answers_pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
